// ===== sv/i2a_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
`default_nettype none

package i2a_pkg;

	// Width of the integer that is converted
	localparam int VALUE_WIDTH = 32;

	// Decimal digits needed for VALUE_WIDTH bits (log10(2) ~ 0.30103)
	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int RAW_W = (VALUE_WIDTH > 4 * DEC_DIGITS) ? VALUE_WIDTH : 4 * DEC_DIGITS;
	// Digit shift register, a multiple of 12 so that 1, 3 and 4 bit digits all fit
	localparam int SR_W = ((RAW_W + 11) / 12) * 12;
	localparam int DIG_CNT_W = $clog2(SR_W + 1);
	localparam int CONV_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int PFX_MAX = 4;
	localparam int PFX_CNT_W = $clog2(PFX_MAX + 1);

	// Conversion selector codes
	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_OCT  = 3'd2;
	localparam logic [2:0] OP_BIN  = 3'd3;
	localparam logic [2:0] OP_HEXL = 3'd4;
	localparam logic [2:0] OP_HEXU = 3'd5;

	// Characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PFX,
		ST_DIGS
	} state_t;

	// Size of one digit in the shift register
	typedef enum logic [1:0] {
		RDX_BIN,
		RDX_OCT,
		RDX_NIB
	} radix_t;

	typedef logic [PFX_MAX-1:0][7:0] pfx_t;

endpackage

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: bit-serial conversion and character output.
`default_nettype none

// One word in; characters out one per cycle while out_ready is high, most significant digit
// first, last marks the end. Words are handled one at a time: in_ready is high only while the
// block is idle. Decimal runs a bit-serial double-dabble over the VALUE_WIDTH bits, then every
// form emits its prefix characters and walks a 48 bit digit register one digit position per
// cycle, dropping leading zeros without output; a character waits while out_ready is low. The
// register holds 12 decimal or hex, 16 octal or 48 binary digit positions, and there are 0 to
// 4 sign and prefix characters. A word with an unused selector (6 or 7) is taken and dropped
// without output.
module integer_to_ascii_formatter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] value,
	input  wire logic        plus_flag,
	input  wire logic        space_flag,
	input  wire logic        alt_flag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       char_code,
	output logic             last
);
	import i2a_pkg::*;

	state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [SR_W-1:0]        sr_q;
	logic [CONV_CNT_W-1:0]  conv_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_n_q;
	logic                   started_q;
	radix_t                 radix_q;
	logic                   upper_q;
	pfx_t                   pfx_q;
	logic [PFX_CNT_W-1:0]   pfx_n_q;

	logic       out_valid_q;
	logic [7:0] char_q;
	logic       last_q;

	// Input decode
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic                   neg;
	logic                   is_dec;
	logic                   is_oct;
	logic                   is_hex;
	logic                   op_ok;
	radix_t                 radix_in;
	logic [DIG_CNT_W-1:0]   dig_n_in;

	always_comb begin
		raw    = VALUE_WIDTH'(value);
		neg    = (operation == OP_SDEC) && raw[VALUE_WIDTH-1];
		mag_in = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
		is_dec = (operation == OP_SDEC) || (operation == OP_UDEC);
		is_oct = (operation == OP_OCT);
		is_hex = (operation == OP_HEXL) || (operation == OP_HEXU);
		op_ok  = is_dec || is_oct || is_hex || (operation == OP_BIN);
		if (is_oct) begin
			radix_in = RDX_OCT;
			dig_n_in = DIG_CNT_W'(SR_W / 3);
		end else if (operation == OP_BIN) begin
			radix_in = RDX_BIN;
			dig_n_in = DIG_CNT_W'(SR_W);
		end else begin
			radix_in = RDX_NIB;
			dig_n_in = DIG_CNT_W'(SR_W / 4);
		end
	end

	// Sign and radix prefix, packed from slot 0 upward
	logic [PFX_MAX-1:0]      pen;
	logic [PFX_MAX-1:0][7:0] pch;
	pfx_t                    pfx_in;
	logic [PFX_CNT_W-1:0]    pfx_n_in;

	always_comb begin
		pen = '0;
		pch = '0;
		if (operation == OP_SDEC) begin
			pen[0] = neg || plus_flag || space_flag;
			pch[0] = neg ? CH_MINUS : (plus_flag ? CH_PLUS : CH_SPACE);
		end else begin
			pen[0] = plus_flag;
			pch[0] = CH_PLUS;
			pen[1] = space_flag;
			pch[1] = CH_SPACE;
			pen[2] = alt_flag && (is_oct || is_hex);
			pch[2] = CH_ZERO;
			pen[3] = alt_flag && is_hex;
			pch[3] = (operation == OP_HEXU) ? CH_UX : CH_LX;
		end
		pfx_in   = '0;
		pfx_n_in = '0;
		for (int i = 0; i < PFX_MAX; i++) begin
			if (pen[i]) begin
				pfx_in[pfx_n_in[$clog2(PFX_MAX)-1:0]] = pch[i];
				pfx_n_in = pfx_n_in + PFX_CNT_W'(1);
			end
		end
	end

	// Top digit of the shift register and its character
	logic [3:0] digit;
	logic [7:0] digit_ch;

	always_comb begin
		unique case (radix_q)
			RDX_BIN: digit = {3'b000, sr_q[SR_W-1]};
			RDX_OCT: digit = {1'b0, sr_q[SR_W-1 -: 3]};
			default: digit = sr_q[SR_W-1 -: 4];
		endcase
		if (digit < 4'd10) begin
			digit_ch = CH_ZERO + {4'h0, digit};
		end else begin
			digit_ch = (upper_q ? CH_UA : CH_LA) + {4'h0, digit} - 8'd10;
		end
	end

	// Double-dabble adjust: add 3 to every BCD digit of 5 or more
	logic [SR_W-1:0] bcd_adj;

	always_comb begin
		for (int i = 0; i < SR_W / 4; i++) begin
			if (sr_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = sr_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = sr_q[4*i +: 4];
			end
		end
	end

	// Control outputs
	logic slot_free;
	logic load;
	logic conv_step;
	logic pfx_emit;
	logic dig_skip;
	logic dig_emit;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		load      = 1'b0;
		conv_step = 1'b0;
		pfx_emit  = 1'b0;
		dig_skip  = 1'b0;
		dig_emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: load = in_valid;
			ST_CONV: conv_step = 1'b1;
			ST_PFX:  pfx_emit = slot_free;
			ST_DIGS: begin
				if (!started_q && (digit == 4'd0) && (dig_n_q > DIG_CNT_W'(1))) begin
					dig_skip = 1'b1;
				end else begin
					dig_emit = slot_free;
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && op_ok) begin
					if (is_dec) begin
						state_d = ST_CONV;
					end else if (pfx_n_in != '0) begin
						state_d = ST_PFX;
					end else begin
						state_d = ST_DIGS;
					end
				end
			end
			ST_CONV: begin
				if (conv_cnt_q == CONV_CNT_W'(1)) begin
					state_d = (pfx_n_q != '0) ? ST_PFX : ST_DIGS;
				end
			end
			ST_PFX: begin
				if (pfx_emit && (pfx_n_q == PFX_CNT_W'(1))) begin
					state_d = ST_DIGS;
				end
			end
			ST_DIGS: begin
				if (dig_emit && (dig_n_q == DIG_CNT_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			pfx_n_q    <= '0;
			dig_n_q    <= '0;
			conv_cnt_q <= '0;
		end else begin
			if (load) begin
				started_q  <= 1'b0;
				pfx_n_q    <= pfx_n_in;
				dig_n_q    <= dig_n_in;
				conv_cnt_q <= CONV_CNT_W'(VALUE_WIDTH);
			end else begin
				if (conv_step) begin
					conv_cnt_q <= conv_cnt_q - CONV_CNT_W'(1);
				end
				if (pfx_emit) begin
					pfx_n_q <= pfx_n_q - PFX_CNT_W'(1);
				end
				if (dig_skip || dig_emit) begin
					dig_n_q <= dig_n_q - DIG_CNT_W'(1);
				end
				if (dig_emit) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q   <= mag_in;
			sr_q    <= is_dec ? '0 : SR_W'(mag_in);
			radix_q <= radix_in;
			upper_q <= (operation == OP_HEXU);
			pfx_q   <= pfx_in;
		end else begin
			if (conv_step) begin
				sr_q  <= {bcd_adj[SR_W-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			end
			if (pfx_emit) begin
				pfx_q <= pfx_q >> 8;
			end
			if (dig_skip || dig_emit) begin
				unique case (radix_q)
					RDX_BIN: sr_q <= {sr_q[SR_W-2:0], 1'b0};
					RDX_OCT: sr_q <= {sr_q[SR_W-4:0], 3'b000};
					default: sr_q <= {sr_q[SR_W-5:0], 4'h0};
				endcase
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pfx_emit || dig_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pfx_emit) begin
			char_q <= pfx_q[0];
			last_q <= 1'b0;
		end else if (dig_emit) begin
			char_q <= digit_ch;
			last_q <= (dig_n_q == DIG_CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire
